@@ sv/grid_block_ray_walk_assert.svh @@
// ----------------------------------------------------------------------------
// grid_block_ray_walk assertion macros
// Shared property forms for the ray walk checker.
// ----------------------------------------------------------------------------
`ifndef GRID_BLOCK_RAY_WALK_ASSERT_SVH
`define GRID_BLOCK_RAY_WALK_ASSERT_SVH

// same-cycle implication, clocked on clk, off during rst
`define GBRW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, clocked on clk, off during rst
`define GBRW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/gbrw_pkg.sv @@
// ----------------------------------------------------------------------------
// gbrw_pkg
// Types and constants shared by the ray walk modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gbrw_pkg;

  localparam int FRAC_BITS = 16;
  localparam int MAP_W     = 17;   // block index plus walk headroom
  localparam int CELL_W    = 9;
  localparam int IN_W      = 128;
  localparam int OUT_W     = 24;
  localparam int CFG_IDX_W = 1;

  localparam logic [31:0] FRAC_ONE    = 32'h0001_0000;
  localparam logic [16:0] PARTIAL_ONE = 17'h1_0000;
  localparam logic [31:0] NO_STEP     = 32'h0100_0000;  // 256.0
  localparam logic [31:0] SAT_POS     = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_NEG     = 32'h8000_0000;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 1'b1;

  typedef enum logic [1:0] {DIR_NONE, DIR_POS, DIR_NEG} dir_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_XLATE, ST_NUDGE, ST_SETUP,
    ST_DIVY_GO, ST_DIVY_WAIT, ST_DIVX_GO, ST_DIVX_WAIT,
    ST_MULY, ST_ADDY, ST_MULX, ST_ADDX,
    ST_WALK_GO, ST_WALK_WAIT
  } seq_state_t;

  typedef enum logic [1:0] {DV_IDLE, DV_CHECK, DV_RUN, DV_SIGN} div_state_t;

  typedef struct packed {
    logic               start;
    logic signed [32:0] num;
    logic        [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quo;
  } div_rsp_t;

  typedef struct packed {
    logic signed [MAP_W-1:0] map_x;
    logic signed [MAP_W-1:0] map_y;
    logic signed [MAP_W-1:0] end_cx;
    logic signed [MAP_W-1:0] end_cy;
    logic        [31:0]      xint;
    logic        [31:0]      yint;
    logic        [31:0]      xstep;
    logic        [31:0]      ystep;
    dir_t                    dir_x;
    dir_t                    dir_y;
  } walk_init_t;

endpackage

`default_nettype wire

@@ sv/gbrw_div.sv @@
// ----------------------------------------------------------------------------
// gbrw_div
// Serial saturating 16.16 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gbrw_div (
  input  logic              clk,
  input  logic              rst,
  input  gbrw_pkg::div_req_t req,
  output gbrw_pkg::div_rsp_t rsp
);
  import gbrw_pkg::*;

  div_state_t state, state_next;
  logic        done;
  logic        neg;
  logic        sat;
  logic [31:0] mag;
  logic [31:0] den;
  logic [31:0] rem;
  logic [30:0] nbits;
  logic [30:0] quo;
  logic [4:0]  cnt;
  logic [31:0] result;

  logic [32:0] num_neg;
  logic [32:0] trial;
  logic [32:0] diff;
  logic        ge;
  logic        sat_hit;

  assign num_neg = 33'd0 - req.num;
  assign trial   = {rem, nbits[30]};
  assign diff    = trial - {1'b0, den};
  assign ge      = trial >= {1'b0, den};
  assign sat_hit = {14'd0, mag[31:14]} >= den;

  always_comb begin
    state_next = state;
    unique case (state)
      DV_IDLE:  if (req.start) state_next = DV_CHECK;
      DV_CHECK: state_next = sat_hit ? DV_SIGN : DV_RUN;
      DV_RUN:   if (cnt == 5'd0) state_next = DV_SIGN;
      DV_SIGN:  state_next = DV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DV_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == DV_SIGN);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      DV_IDLE: begin
        if (req.start) begin
          neg <= req.num[32];
          mag <= req.num[32] ? num_neg[31:0] : req.num[31:0];
          den <= req.den;
        end
      end
      DV_CHECK: begin
        sat   <= sat_hit;
        rem   <= {15'd0, mag[31:15]};
        nbits <= {mag[14:0], 16'd0};
        cnt   <= 5'd30;
      end
      DV_RUN: begin
        rem   <= ge ? diff[31:0] : trial[31:0];
        quo   <= {quo[29:0], ge};
        nbits <= {nbits[29:0], 1'b0};
        cnt   <= cnt - 5'd1;
      end
      DV_SIGN: begin
        if (sat) result <= neg ? SAT_NEG : SAT_POS;
        else     result <= neg ? (32'd0 - {1'b0, quo}) : {1'b0, quo};
      end
      default: ;
    endcase
  end

  assign rsp.done = done;
  assign rsp.quo  = result;

endmodule

`default_nettype wire

@@ sv/gbrw_walk.sv @@
// ----------------------------------------------------------------------------
// gbrw_walk
// Cell stepper: one visited cell per output transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gbrw_walk #(
  parameter int MAX_STEPS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  gbrw_pkg::walk_init_t          init,
  input  logic                          ready,
  output logic                          valid,
  output logic [gbrw_pkg::CELL_W-1:0]   cell_x,
  output logic [gbrw_pkg::CELL_W-1:0]   cell_y,
  output logic                          last
);
  import gbrw_pkg::*;

  localparam int CNT_W = $clog2(MAX_STEPS + 1);

  logic signed [MAP_W-1:0] map_x, map_y, end_cx, end_cy;
  logic        [31:0]      xint, yint, xstep, ystep;
  dir_t                    dir_x, dir_y;
  logic        [CNT_W-1:0] count;

  logic signed [MAP_W-1:0] ycell, xcell;
  logic                    at_end, yhit, xhit, adv;

  function automatic logic signed [MAP_W-1:0] move(logic signed [MAP_W-1:0] m, dir_t d);
    case (d)
      DIR_POS: move = m + MAP_W'(1);
      DIR_NEG: move = m - MAP_W'(1);
      default: move = m;
    endcase
  endfunction

  assign ycell  = MAP_W'($signed(yint[31:FRAC_BITS]));
  assign xcell  = MAP_W'($signed(xint[31:FRAC_BITS]));
  assign at_end = (map_x == end_cx) && (map_y == end_cy);
  assign last   = at_end || (count == CNT_W'(MAX_STEPS - 1));
  assign yhit   = (ycell == map_y);
  assign xhit   = (xcell == map_x);
  assign adv    = valid && ready && !last;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (start) begin
      valid <= 1'b1;
    end else if (valid && ready && last) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      map_x  <= init.map_x;
      map_y  <= init.map_y;
      end_cx <= init.end_cx;
      end_cy <= init.end_cy;
      xint   <= init.xint;
      yint   <= init.yint;
      xstep  <= init.xstep;
      ystep  <= init.ystep;
      dir_x  <= init.dir_x;
      dir_y  <= init.dir_y;
      count  <= '0;
    end else if (adv) begin
      count <= count + CNT_W'(1);
      if (yhit) begin
        yint  <= yint + ystep;
        map_x <= move(map_x, dir_x);
      end else if (xhit) begin
        xint  <= xint + xstep;
        map_y <= move(map_y, dir_y);
      end
      // neither hit: stalled step repeats the cell
    end
  end

  assign cell_x = map_x[CELL_W-1:0];
  assign cell_y = map_y[CELL_W-1:0];

endmodule

`default_nettype wire

@@ sv/grid_block_ray_walk.sv @@
// ----------------------------------------------------------------------------
// grid_block_ray_walk
// Block-grid traversal of a 16.16 segment, one cell per output transaction.
// ----------------------------------------------------------------------------
// One segment is taken at a time: s_tready is high only while the block is
// idle. After a segment is accepted the block translates it by the origin
// registers, nudges start coordinates that sit on a block edge by +1.0, and
// runs up to two saturating 16.16 divisions back to back on one shared
// serial divider (one quotient bit per cycle), skipping a division whose
// axis crosses no block edge. Then cells come out one per cycle while
// m_tready is high, up to MAX_STEPS cells, the final one with m_tlast.
// Origin writes are taken any time but belong between segments.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module grid_block_ray_walk #(
  parameter int BLOCK_SHIFT = 23,
  parameter int MAX_STEPS   = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration writes
  input  logic                             cfg_we,
  input  logic [gbrw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                      cfg_data,
  // segment input
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [gbrw_pkg::IN_W-1:0]        s_tdata,  // start_x, start_y, end_x, end_y
  // cell output
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [gbrw_pkg::OUT_W-1:0]       m_tdata,  // cell_x, cell_y, zero pad
  output logic                             m_tlast   // last cell of segment
);
  import gbrw_pkg::*;

  localparam int BTOFRAC = BLOCK_SHIFT - FRAC_BITS;

  seq_state_t state, state_next;

  // origin registers
  logic [31:0] ox, oy;

  // segment datapath
  logic [31:0]        x1, y1, x2, y2;
  dir_t               dir_x, dir_y;
  logic signed [32:0] dx, dy;
  logic [16:0]        frac_x, frac_y;   // partial distance to first edge
  logic [31:0]        xstep, ystep;
  logic signed [49:0] prod;
  logic [31:0]        xint, yint;

  logic signed [MAP_W-1:0] xt1, yt1, xt2, yt2;
  logic [15:0]             fx, fy;
  logic [32:0]             dx_neg, dy_neg;
  logic [31:0]             adx, ady;

  div_req_t   dreq;
  div_rsp_t   drsp;
  walk_init_t winit;
  logic       walk_start, walk_valid;
  logic [CELL_W-1:0] cell_x, cell_y;
  logic       walk_last;

  // block indices and first-edge fractions
  assign xt1 = MAP_W'($signed(x1) >>> BLOCK_SHIFT);
  assign yt1 = MAP_W'($signed(y1) >>> BLOCK_SHIFT);
  assign xt2 = MAP_W'($signed(x2) >>> BLOCK_SHIFT);
  assign yt2 = MAP_W'($signed(y2) >>> BLOCK_SHIFT);
  assign fx  = x1[BTOFRAC +: FRAC_BITS];
  assign fy  = y1[BTOFRAC +: FRAC_BITS];

  assign dx_neg = 33'd0 - dx;
  assign dy_neg = 33'd0 - dy;
  assign adx    = dx[32] ? dx_neg[31:0] : dx[31:0];
  assign ady    = dy[32] ? dy_neg[31:0] : dy[31:0];

  assign s_tready = (state == ST_IDLE);

  // config port
  always_ff @(posedge clk) begin
    if (rst) begin
      ox <= '0;
      oy <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ORIGIN_X: ox <= cfg_data;
        REG_ORIGIN_Y: oy <= cfg_data;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    dreq.start = 1'b0;
    dreq.num   = (state == ST_DIVY_GO) ? dy : dx;
    dreq.den   = (state == ST_DIVY_GO) ? adx : ady;
    walk_start = 1'b0;
    unique case (state)
      ST_IDLE:      if (s_tvalid) state_next = ST_XLATE;
      ST_XLATE:     state_next = ST_NUDGE;
      ST_NUDGE:     state_next = ST_SETUP;
      ST_SETUP:     state_next = ST_DIVY_GO;
      ST_DIVY_GO: begin
        dreq.start = (dir_x != DIR_NONE);
        state_next = (dir_x != DIR_NONE) ? ST_DIVY_WAIT : ST_DIVX_GO;
      end
      ST_DIVY_WAIT: if (drsp.done) state_next = ST_DIVX_GO;
      ST_DIVX_GO: begin
        dreq.start = (dir_y != DIR_NONE);
        state_next = (dir_y != DIR_NONE) ? ST_DIVX_WAIT : ST_MULY;
      end
      ST_DIVX_WAIT: if (drsp.done) state_next = ST_MULY;
      ST_MULY:      state_next = ST_ADDY;
      ST_ADDY:      state_next = ST_MULX;
      ST_MULX:      state_next = ST_ADDX;
      ST_ADDX:      state_next = ST_WALK_GO;
      ST_WALK_GO: begin
        walk_start = 1'b1;
        state_next = ST_WALK_WAIT;
      end
      ST_WALK_WAIT: if (!walk_valid) state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // setup datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          x1 <= s_tdata[31:0];
          y1 <= s_tdata[63:32];
          x2 <= s_tdata[95:64];
          y2 <= s_tdata[127:96];
        end
      end
      ST_XLATE: begin
        x1 <= x1 - ox;
        y1 <= y1 - oy;
        x2 <= x2 - ox;
        y2 <= y2 - oy;
      end
      ST_NUDGE: begin
        // start exactly on a block edge moves in by 1.0
        if (x1[BLOCK_SHIFT-1:0] == '0) x1 <= x1 + FRAC_ONE;
        if (y1[BLOCK_SHIFT-1:0] == '0) y1 <= y1 + FRAC_ONE;
      end
      ST_SETUP: begin
        dx <= {x2[31], x2} - {x1[31], x1};
        dy <= {y2[31], y2} - {y1[31], y1};
        if (xt2 > xt1) begin
          dir_x  <= DIR_POS;
          frac_x <= PARTIAL_ONE - {1'b0, fx};
        end else if (xt2 < xt1) begin
          dir_x  <= DIR_NEG;
          frac_x <= {1'b0, fx};
        end else begin
          dir_x  <= DIR_NONE;
          frac_x <= PARTIAL_ONE;
        end
        if (yt2 > yt1) begin
          dir_y  <= DIR_POS;
          frac_y <= PARTIAL_ONE - {1'b0, fy};
        end else if (yt2 < yt1) begin
          dir_y  <= DIR_NEG;
          frac_y <= {1'b0, fy};
        end else begin
          dir_y  <= DIR_NONE;
          frac_y <= PARTIAL_ONE;
        end
      end
      ST_DIVY_GO:   if (dir_x == DIR_NONE) ystep <= NO_STEP;
      ST_DIVY_WAIT: if (drsp.done) ystep <= drsp.quo;
      ST_DIVX_GO:   if (dir_y == DIR_NONE) xstep <= NO_STEP;
      ST_DIVX_WAIT: if (drsp.done) xstep <= drsp.quo;
      ST_MULY:      prod <= $signed({1'b0, frac_x}) * $signed(ystep);
      ST_ADDY:      yint <= 32'($signed(y1) >>> BTOFRAC) + prod[47:16];
      ST_MULX:      prod <= $signed({1'b0, frac_y}) * $signed(xstep);
      ST_ADDX:      xint <= 32'($signed(x1) >>> BTOFRAC) + prod[47:16];
      default: ;
    endcase
  end

  gbrw_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  assign winit.map_x  = xt1;
  assign winit.map_y  = yt1;
  assign winit.end_cx = xt2;
  assign winit.end_cy = yt2;
  assign winit.xint   = xint;
  assign winit.yint   = yint;
  assign winit.xstep  = xstep;
  assign winit.ystep  = ystep;
  assign winit.dir_x  = dir_x;
  assign winit.dir_y  = dir_y;

  gbrw_walk #(
    .MAX_STEPS (MAX_STEPS)
  ) u_walk (
    .clk    (clk),
    .rst    (rst),
    .start  (walk_start),
    .init   (winit),
    .ready  (m_tready),
    .valid  (walk_valid),
    .cell_x (cell_x),
    .cell_y (cell_y),
    .last   (walk_last)
  );

  assign m_tvalid = walk_valid;
  assign m_tdata  = {(OUT_W - 2 * CELL_W)'(0), cell_y, cell_x};
  assign m_tlast  = walk_last;

endmodule

`default_nettype wire

@@ sv/gbrw_check.sv @@
// ----------------------------------------------------------------------------
// gbrw_check
// Port-level checks for the ray walk, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "grid_block_ray_walk_assert.svh"

module gbrw_check (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_tvalid,
  input logic                         s_tready,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [gbrw_pkg::OUT_W-1:0]   m_tdata,
  input logic                         m_tlast
);

  // input side stays closed while cells of a segment are out
  `GBRW_ASSERT_NOW(a_no_overlap, m_tvalid, !s_tready, "input ready while cells pending")

  // setup always takes cycles after a segment transaction
  `GBRW_ASSERT_NEXT(a_setup_gap, s_tvalid && s_tready, !m_tvalid, "cell right after segment")

  // nothing follows the last cell of a segment
  `GBRW_ASSERT_NEXT(a_last_ends, m_tvalid && m_tready && m_tlast, !m_tvalid, "cell after last")

  // stalled cell holds
  `GBRW_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled cell changed")

endmodule

bind grid_block_ray_walk gbrw_check u_check (.*);

`default_nettype wire

@@ bench/grid_walk_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_walk_checker
// Watches the origin writes and both stream channels of the ray walk, works
// out the cells each accepted segment must produce and compares every cell
// transaction with the oldest one still due.
// ----------------------------------------------------------------------------
module grid_walk_checker #(
  parameter int BLOCK_SHIFT = 23,
  parameter int MAX_STEPS   = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [gbrw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [gbrw_pkg::IN_W-1:0]      s_tdata,  // start_x, start_y, end_x, end_y
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [gbrw_pkg::OUT_W-1:0]     m_tdata,  // cell_x, cell_y, zero pad
  input  logic                           m_tlast,
  output int                             mismatches,
  output int                             pending
);
  import gbrw_pkg::*;

  localparam int     BTOFRAC   = BLOCK_SHIFT - FRAC_BITS;
  localparam longint ONE       = 64'sd65536;
  localparam longint FRAC_MASK = 64'sd65535;
  localparam longint FLAT_STEP = 64'sd16777216;  // 256.0
  localparam longint QUO_MAX   = 64'sh0000_0000_7FFF_FFFF;
  localparam longint QUO_MIN   = 64'shFFFF_FFFF_8000_0000;

  typedef struct packed {
    logic [CELL_W-1:0] cx;
    logic [CELL_W-1:0] cy;
    logic              lst;
  } cell_t;

  cell_t       cells_due[$];
  logic [31:0] org_x, org_y;

  function automatic longint wrap32(input longint v);
    int t;
    t = v[31:0];
    return t;
  endfunction

  function automatic longint mag(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // saturating 16.16 quotient, truncated toward zero
  function automatic longint sat_div(input longint a, input longint b);
    if ((mag(a) >>> 14) >= mag(b))
      return ((a < 0) != (b < 0)) ? QUO_MIN : QUO_MAX;
    return (a * 65536) / b;
  endfunction

  function automatic longint fx_mul(input longint a, input longint b);
    return (a * b) >>> FRAC_BITS;
  endfunction

  task automatic predict_walk(input logic [31:0] sx, sy, ex, ey);
    longint x1, y1, x2, y2, xt1, yt1, xt2, yt2;
    longint xstep, ystep, part, xint, yint, mx, my, sdx, sdy;
    int     n;
    logic   fin;
    cell_t  c;
    x1 = wrap32(wrap32(sx) - wrap32(org_x));
    y1 = wrap32(wrap32(sy) - wrap32(org_y));
    x2 = wrap32(wrap32(ex) - wrap32(org_x));
    y2 = wrap32(wrap32(ey) - wrap32(org_y));
    // start sitting on a block edge moves in by 1.0
    if (x1[BLOCK_SHIFT-1:0] == '0) x1 = wrap32(x1 + ONE);
    if (y1[BLOCK_SHIFT-1:0] == '0) y1 = wrap32(y1 + ONE);
    xt1 = x1 >>> BLOCK_SHIFT;
    yt1 = y1 >>> BLOCK_SHIFT;
    xt2 = x2 >>> BLOCK_SHIFT;
    yt2 = y2 >>> BLOCK_SHIFT;

    if (xt2 > xt1) begin
      sdx   = 1;
      part  = ONE - ((x1 >>> BTOFRAC) & FRAC_MASK);
      ystep = sat_div(y2 - y1, mag(x2 - x1));
    end else if (xt2 < xt1) begin
      sdx   = -1;
      part  = (x1 >>> BTOFRAC) & FRAC_MASK;
      ystep = sat_div(y2 - y1, mag(x2 - x1));
    end else begin
      sdx   = 0;
      part  = ONE;
      ystep = FLAT_STEP;
    end
    yint = wrap32((y1 >>> BTOFRAC) + fx_mul(part, ystep));

    if (yt2 > yt1) begin
      sdy   = 1;
      part  = ONE - ((y1 >>> BTOFRAC) & FRAC_MASK);
      xstep = sat_div(x2 - x1, mag(y2 - y1));
    end else if (yt2 < yt1) begin
      sdy   = -1;
      part  = (y1 >>> BTOFRAC) & FRAC_MASK;
      xstep = sat_div(x2 - x1, mag(y2 - y1));
    end else begin
      sdy   = 0;
      part  = ONE;
      xstep = FLAT_STEP;
    end
    xint = wrap32((x1 >>> BTOFRAC) + fx_mul(part, xstep));

    mx = xt1;
    my = yt1;
    for (n = 0; n < MAX_STEPS; n++) begin
      fin   = ((mx == xt2) && (my == yt2)) || (n == MAX_STEPS - 1);
      c.cx  = mx[CELL_W-1:0];
      c.cy  = my[CELL_W-1:0];
      c.lst = fin;
      cells_due.push_back(c);
      if (fin) break;
      // neither intercept matching leaves the cell as it is
      if ((yint >>> FRAC_BITS) == my) begin
        yint = wrap32(yint + ystep);
        mx   = mx + sdx;
      end else if ((xint >>> FRAC_BITS) == mx) begin
        xint = wrap32(xint + xstep);
        my   = my + sdy;
      end
    end
  endtask

  task automatic flag_field(input string what, input logic [CELL_W-1:0] want,
                            input logic [CELL_W-1:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s mismatch, expected %h got %h", $realtime, what, want, got);
  endtask

  always @(posedge clk) begin : watch
    cell_t want;
    if (rst) begin
      cells_due.delete();
      org_x      = '0;
      org_y      = '0;
      mismatches = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ORIGIN_X: org_x = cfg_data;
          REG_ORIGIN_Y: org_y = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        predict_walk(s_tdata[31:0], s_tdata[63:32], s_tdata[95:64], s_tdata[127:96]);
      if (m_tvalid && m_tready) begin
        if (cells_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: cell x=%h y=%h last=%b with none due", $realtime,
                     m_tdata[8:0], m_tdata[17:9], m_tlast);
        end else begin
          want = cells_due.pop_front();
          if (m_tdata[8:0] !== want.cx)  flag_field("cell_x", want.cx, m_tdata[8:0]);
          if (m_tdata[17:9] !== want.cy) flag_field("cell_y", want.cy, m_tdata[17:9]);
          if (m_tlast !== want.lst)      flag_field("last", want.lst, m_tlast);
        end
      end
    end
    pending = cells_due.size();
  end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for grid_block_ray_walk. Segments go in through the
// slave stream in bursts, cells are drained through the master stream under
// a changing stall pattern, and the origin registers are moved between
// phases. All checking lives in grid_walk_checker.
// ----------------------------------------------------------------------------
module tb;
  import gbrw_pkg::*;

  localparam int          BLOCK_SHIFT = 23;
  localparam int          MAX_STEPS   = 64;
  localparam logic [31:0] BLOCK_MASK  = (32'd1 << BLOCK_SHIFT) - 1;
  localparam int          PHASES      = 5;
  localparam int          RAND_PER_PH = 18;   // about 110 segments in all with the directed ones
  localparam int          HOLD_CYCLES = 600;  // long output stall, well past a segment
  localparam int          SETTLE      = 10;   // idle margin before an origin write
  localparam int          TAIL        = 200;  // watch for stray cells at the end

  typedef enum int {RX_FREE, RX_RANDOM, RX_CHOKED} rx_mode_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [IN_W-1:0]      s_tdata;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [OUT_W-1:0]     m_tdata;
  logic                 m_tlast;

  int          mismatches;
  int          pending;
  logic        hold_req;      // asks the receiver for one long stall
  logic [31:0] cur_ox, cur_oy;
  int          burst_left;

  grid_block_ray_walk #(
    .BLOCK_SHIFT(BLOCK_SHIFT),
    .MAX_STEPS  (MAX_STEPS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  grid_walk_checker #(
    .BLOCK_SHIFT(BLOCK_SHIFT),
    .MAX_STEPS  (MAX_STEPS)
  ) i_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .mismatches(mismatches),
    .pending   (pending)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop. The worst legit run is ~110 segments, each with setup, up to
  // 64 cells under a choked receiver and a gap, plus the long stall; the
  // stop lies well past that.
  initial begin
    #3_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // tdata layout, low bits first: start_x, start_y, end_x, end_y
  function automatic logic [IN_W-1:0] segment(input logic [31:0] sx, sy, ex, ey);
    return {ey, ex, sy, sx};
  endfunction

  // uniform offset in -span..+span, wraps like the block does
  function automatic logic [31:0] jitter(input int unsigned span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  // Random segment. Mostly short hops of a few blocks; some full-range
  // spans (these hit the step cap), axis-parallel runs, near-vertical and
  // near-horizontal ones that drive the divider into saturation, and starts
  // placed exactly on a block edge of the current grid.
  function automatic logic [IN_W-1:0] random_segment();
    logic [31:0] sx, sy, ex, ey;
    int unsigned pick;
    logic        flip;
    pick = $urandom_range(0, 9);
    flip = $urandom_range(0, 1);
    sx   = $urandom;
    sy   = $urandom;
    if (pick <= 3) begin
      ex = sx + jitter(1 << 25);
      ey = sy + jitter(1 << 25);
    end else if (pick == 4) begin
      ex = $urandom;
      ey = $urandom;
    end else if (pick == 5) begin
      ex = flip ? sx : sx + jitter(1 << 27);
      ey = flip ? sy + jitter(1 << 27) : sy;
    end else if (pick == 6) begin
      ex = flip ? sx + jitter(1 << 12) : sx + jitter(1 << 29);
      ey = flip ? sy + jitter(1 << 29) : sy + jitter(1 << 12);
    end else begin
      // block-edge starts: both, x only, y only
      if (pick != 9) sx = cur_ox + ($urandom & ~BLOCK_MASK);
      if (pick != 8) sy = cur_oy + ($urandom & ~BLOCK_MASK);
      ex = sx + jitter(1 << 25);
      ey = sy + jitter(1 << 25);
    end
    return segment(sx, sy, ex, ey);
  endfunction

  // Register writes must happen only with the block idle; the task does not enforce it, the caller drains first.
  task automatic write_origin(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we    = 1'b0;
    if (idx == REG_ORIGIN_X) cur_ox = val;
    else                     cur_oy = val;
  endtask

  // Sender pause: hold off until every due cell has come back.
  task automatic drain();
    while (pending != 0) @(negedge clk);
  endtask

  // One segment transaction. Valid stays up across a burst; after the burst
  // runs out a random gap follows and a new burst length is drawn.
  task automatic offer(input logic [IN_W-1:0] seg);
    s_tdata  = seg;
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 20)) @(negedge clk);
      burst_left = $urandom_range(1, 6);
    end
  endtask

  // Receiver: phases of free flow, coin-flip stalls and heavy stalls, plus
  // one long hold on request so the walk backs up into the input side.
  initial begin : receiver
    rx_mode_t mode;
    int       span;
    m_tready = 1'b0;
    hold_req = 1'b0;
    forever begin
      if (hold_req) begin
        m_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        mode = rx_mode_t'($urandom_range(0, 2));
        span = $urandom_range(4, 60);
        repeat (span) begin
          case (mode)
            RX_FREE:   m_tready = 1'b1;
            RX_RANDOM: m_tready = $urandom_range(0, 1);
            default:   m_tready = ($urandom_range(0, 3) == 0);
          endcase
          @(negedge clk);
          if (hold_req) break;
        end
      end
    end
  end

  initial begin : stimulus
    logic [31:0] ox_set[PHASES];
    logic [31:0] oy_set[PHASES];
    int          ph;
    int          k;
    // grid origins per phase: zero, both extremes crossed, then random (the last keeps y at zero)
    ox_set = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, $urandom, $urandom};
    oy_set = '{32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF, $urandom, 32'h0000_0000};

    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    cur_ox     = '0;
    cur_oy     = '0;
    burst_left = $urandom_range(1, 6);
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (ph = 0; ph < PHASES; ph++) begin
      // block idle: every due cell back plus the SETTLE margin for the last one
      drain();
      repeat (SETTLE) @(negedge clk);
      write_origin(REG_ORIGIN_X, ox_set[ph]);
      write_origin(REG_ORIGIN_Y, oy_set[ph]);

      if (ph == 0) begin
        // directed, grid at zero
        offer(segment(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000));
        offer(segment(32'h0010_0000, 32'h0020_0000, 32'h0030_0000, 32'h0040_0000));
        // axis-parallel runs in all four directions
        offer(segment(32'h0012_3456, 32'h0040_0000, 32'h0500_0000, 32'h0040_0000));
        offer(segment(32'h0500_1234, 32'h0040_0000, 32'h0012_3456, 32'h0040_0000));
        offer(segment(32'h0040_0000, 32'h0012_3456, 32'h0040_0000, 32'h0500_0000));
        offer(segment(32'h0040_0000, 32'h0500_1234, 32'h0040_0000, 32'h0012_3456));
        // diagonals
        offer(segment(32'h0010_0000, 32'h0010_0000, 32'h0410_0000, 32'h0410_0000));
        offer(segment(32'h0010_0000, 32'h0010_0000, 32'hFC10_0000, 32'hFC10_0000));
        // full-range spans, stopped by the step cap
        offer(segment(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000));
        offer(segment(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        offer(segment(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
        // one column crossed by a tiny dx: y step saturates both ways
        offer(segment(32'h007F_FF00, 32'h0000_1000, 32'h0080_0100, 32'h4000_0000));
        offer(segment(32'h007F_FF00, 32'h4000_0000, 32'h0080_0100, 32'h0000_1000));
        offer(segment(32'h0080_0100, 32'h0000_1000, 32'h007F_FF00, 32'h4000_0000));
        // same for the x step
        offer(segment(32'h0000_1000, 32'h007F_FF00, 32'h4000_0000, 32'h0080_0100));
        offer(segment(32'h4000_0000, 32'h0080_0100, 32'h0000_1000, 32'h007F_FF00));
        // starts on block edges, walking backward and forward
        offer(segment(32'h0080_0000, 32'h0100_0000, 32'h0040_0000, 32'h00C0_0000));
        offer(segment(32'hFF80_0000, 32'hFF80_0000, 32'h0000_0000, 32'h0000_0000));
        // across zero from -1 ulp
        offer(segment(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001));
        offer(segment(32'h1234_5678, 32'h9ABC_DEF0, 32'hEDCB_A987, 32'h6543_210F));
      end

      for (k = 0; k < RAND_PER_PH; k++) begin
        // long output stall while the sender keeps pushing
        if (ph == 1 && k == 2) hold_req = 1'b1;
        // sender waits for the pipe to empty mid-phase
        if (k == 10) begin
          s_tvalid = 1'b0;
          drain();
        end
        offer(random_segment());
      end
      s_tvalid = 1'b0;
    end

    drain();
    repeat (TAIL) @(negedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
